// ----- rtl/core/nap_pkg.sv -----
`timescale 1ns / 1ps
package nap_pkg;

  localparam int CHAR_W          = 8;
  localparam int FIELD_W         = 16;
  localparam int LEVEL_W         = 3;
  localparam int DIGIT_W         = 4;
  localparam int ORDER_W         = 2;
  localparam int DEF_NUMBER_BITS = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [LEVEL_W-1:0] LVL_NONE  = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_ZONE  = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_NET   = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_NODE  = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_POINT = 3'd4;

  localparam logic [ORDER_W-1:0] ORD_NONE = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_ZONE = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_NET  = 2'd2;

  typedef enum logic [2:0] {
    CC_DIGIT,
    CC_COLON,
    CC_SLASH,
    CC_DOT,
    CC_STAR,
    CC_NUL,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t        cls;
    logic [DIGIT_W-1:0] digit;
    logic               first;
    logic [LEVEL_W-1:0] start_level;
  } token_t;

  function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
    char_class_t cc;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      cc = CC_DIGIT;
    end else begin
      case (c)
        CH_COLON: cc = CC_COLON;
        CH_SLASH: cc = CC_SLASH;
        CH_DOT:   cc = CC_DOT;
        CH_STAR:  cc = CC_STAR;
        CH_NUL:   cc = CC_NUL;
        default:  cc = CC_OTHER;
      endcase
    end
    return cc;
  endfunction

endpackage

// ----- rtl/core/nap_in_if.sv -----
`timescale 1ns / 1ps
interface nap_in_if;
  import nap_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  ch;
  logic               first;
  logic [LEVEL_W-1:0] start_level;

  modport source (output valid, ch, first, start_level, input ready);
  modport sink   (input valid, ch, first, start_level, output ready);
endinterface

// ----- rtl/core/nap_out_if.sv -----
`timescale 1ns / 1ps
interface nap_out_if;
  import nap_pkg::*;

  logic               valid;
  logic               ready;
  logic               status;
  logic [LEVEL_W-1:0] level;
  logic [FIELD_W-1:0] zone;
  logic [FIELD_W-1:0] net;
  logic [FIELD_W-1:0] node;
  logic [FIELD_W-1:0] point;
  logic               zone_written;
  logic               net_written;
  logic               node_written;

  modport source (output valid, status, level, zone, net, node, point,
                  zone_written, net_written, node_written, input ready);
  modport sink   (input valid, status, level, zone, net, node, point,
                  zone_written, net_written, node_written, output ready);
endinterface

// ----- rtl/core/nap_front.sv -----
`timescale 1ns / 1ps
module nap_front (
  input  logic            clk,
  input  logic            rst_n,
  nap_in_if.sink          in_chan,
  output nap_pkg::token_t q_token,
  output logic            q_valid,
  input  logic            q_ready
);
  import nap_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  token_t           slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  token_t           tok_in;
  logic             push, pop;

  always_comb begin
    tok_in.cls         = classify(in_chan.ch);
    tok_in.digit       = DIGIT_W'(in_chan.ch - CH_ZERO);
    tok_in.first       = in_chan.first;
    tok_in.start_level = in_chan.start_level;
  end

  assign in_chan.ready = (count_r != FULL_CNT);
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (count_r != '0);
  assign pop           = q_valid && q_ready;
  assign q_token       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ((wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ((rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= tok_in;
    end
  end

endmodule

// ----- rtl/core/nap_back.sv -----
`timescale 1ns / 1ps
module nap_back #(
  parameter int NUMBER_BITS = nap_pkg::DEF_NUMBER_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  nap_pkg::token_t q_token,
  input  logic            q_valid,
  output logic            q_ready,
  nap_out_if.source       out_chan
);
  import nap_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEG,
    PH_DIGITS,
    PH_STAR,
    PH_PT_START,
    PH_PT_DIGITS,
    PH_PT_STAR
  } phase_t;

  localparam int NB = NUMBER_BITS;

  phase_t             phase_r, ph_nxt;
  logic [ORDER_W-1:0] ord_r, ord_nxt;
  logic [LEVEL_W-1:0] lvl_r, lvl_nxt;
  logic [NB-1:0]      acc_r, acc_nxt;
  logic [NB-1:0]      zone_r, zone_nxt;
  logic [NB-1:0]      net_r, net_nxt;
  logic [NB-1:0]      node_r, node_nxt;
  logic [NB-1:0]      point_r, point_nxt;
  logic [2:0]         wr_r, wr_nxt;
  logic [NB-1:0]      acc_dig, dig_ext;
  logic               emit, err, node_ok, pop;

  logic               out_valid_r;
  logic               out_status_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [FIELD_W-1:0] out_zone_r, out_net_r, out_node_r, out_point_r;
  logic [2:0]         out_wr_r;

  assign q_ready = !out_valid_r || out_chan.ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    ph_nxt    = phase_r;
    ord_nxt   = ord_r;
    lvl_nxt   = lvl_r;
    acc_nxt   = acc_r;
    zone_nxt  = zone_r;
    net_nxt   = net_r;
    node_nxt  = node_r;
    point_nxt = point_r;
    wr_nxt    = wr_r;
    emit      = 1'b0;
    err       = 1'b0;

    if (q_token.first) begin
      ph_nxt    = PH_SEG;
      ord_nxt   = ORD_NONE;
      lvl_nxt   = q_token.start_level;
      acc_nxt   = '0;
      zone_nxt  = '0;
      net_nxt   = '0;
      node_nxt  = '0;
      point_nxt = '0;
      wr_nxt    = '0;
    end

    dig_ext = NB'(q_token.digit);
    acc_dig = NB'({acc_nxt, 3'b000}) + NB'({acc_nxt, 1'b0}) + dig_ext;
    node_ok = !((lvl_nxt < LVL_NET || ord_nxt != ORD_NONE) && ord_nxt != ORD_NET);

    if (q_token.first && q_token.cls == CC_DOT) begin
      if (lvl_nxt >= LVL_NODE) begin
        ph_nxt = PH_PT_START;
      end else begin
        emit = 1'b1;
        err  = 1'b1;
      end
    end else begin
      case (ph_nxt)
        PH_SEG: begin
          if (q_token.cls == CC_STAR && lvl_nxt < LVL_NODE) begin
            ph_nxt = PH_STAR;
          end else if (q_token.cls == CC_DIGIT) begin
            acc_nxt = dig_ext;
            ph_nxt  = PH_DIGITS;
          end else begin
            emit = 1'b1;
            err  = 1'b1;
          end
        end
        PH_DIGITS: begin
          case (q_token.cls)
            CC_DIGIT: acc_nxt = acc_dig;
            CC_COLON: begin
              if (ord_nxt != ORD_NONE) begin
                emit = 1'b1;
                err  = 1'b1;
              end else begin
                ord_nxt   = ORD_ZONE;
                zone_nxt  = acc_nxt;
                wr_nxt[0] = 1'b1;
                lvl_nxt   = LVL_ZONE;
                ph_nxt    = PH_SEG;
              end
            end
            CC_SLASH: begin
              if (acc_nxt == '0 || ord_nxt > ORD_ZONE || lvl_nxt == LVL_NONE) begin
                emit = 1'b1;
                err  = 1'b1;
              end else begin
                ord_nxt   = ORD_NET;
                net_nxt   = acc_nxt;
                wr_nxt[1] = 1'b1;
                lvl_nxt   = LVL_NET;
                ph_nxt    = PH_SEG;
              end
            end
            CC_NUL, CC_DOT: begin
              if (q_token.cls == CC_NUL && lvl_nxt == LVL_NODE) begin
                point_nxt = acc_nxt;
                lvl_nxt   = LVL_POINT;
                emit      = 1'b1;
              end else if (!node_ok) begin
                emit = 1'b1;
                err  = 1'b1;
              end else begin
                node_nxt  = acc_nxt;
                wr_nxt[2] = 1'b1;
                lvl_nxt   = LVL_NODE;
                ph_nxt    = PH_SEG;
                emit      = (q_token.cls == CC_NUL);
              end
            end
            default: begin
              emit = 1'b1;
              err  = 1'b1;
            end
          endcase
        end
        PH_STAR: begin
          emit = 1'b1;
          err  = (q_token.cls != CC_NUL);
        end
        PH_PT_START: begin
          if (q_token.cls == CC_DIGIT) begin
            acc_nxt   = dig_ext;
            point_nxt = dig_ext;
            ph_nxt    = PH_PT_DIGITS;
          end else if (q_token.cls == CC_STAR) begin
            ph_nxt = PH_PT_STAR;
          end else begin
            emit = 1'b1;
            err  = 1'b1;
          end
        end
        PH_PT_DIGITS: begin
          if (q_token.cls == CC_DIGIT) begin
            acc_nxt   = acc_dig;
            point_nxt = acc_dig;
          end else if (q_token.cls == CC_NUL) begin
            lvl_nxt = LVL_POINT;
            emit    = 1'b1;
          end else begin
            emit = 1'b1;
            err  = 1'b1;
          end
        end
        PH_PT_STAR: begin
          emit = 1'b1;
          if (q_token.cls == CC_NUL) begin
            lvl_nxt = LVL_NODE;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      ph_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= ph_nxt;
      end
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (pop) begin
      ord_r   <= ord_nxt;
      lvl_r   <= lvl_nxt;
      acc_r   <= acc_nxt;
      zone_r  <= zone_nxt;
      net_r   <= net_nxt;
      node_r  <= node_nxt;
      point_r <= point_nxt;
      wr_r    <= wr_nxt;
    end
    if (pop && emit) begin
      out_status_r <= err;
      out_level_r  <= lvl_nxt;
      out_zone_r   <= FIELD_W'(zone_nxt);
      out_net_r    <= FIELD_W'(net_nxt);
      out_node_r   <= FIELD_W'(node_nxt);
      out_point_r  <= FIELD_W'(point_nxt);
      out_wr_r     <= wr_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.level        = out_level_r;
  assign out_chan.zone         = out_zone_r;
  assign out_chan.net          = out_net_r;
  assign out_chan.node         = out_node_r;
  assign out_chan.point        = out_point_r;
  assign out_chan.zone_written = out_wr_r[0];
  assign out_chan.net_written  = out_wr_r[1];
  assign out_chan.node_written = out_wr_r[2];

endmodule

// ----- rtl/core/node_address_parser_core.sv -----
// Path: a closing character is first written into the queue, then the parse step
//   takes it from the queue head and registers the result in the output register.
// Throughput: one character per cycle, set by the parse step, while no result waits unaccepted at the output.
// Reset: rst_n synchronous, active low; empties the queue, idles the parser and
//   drops any pending result. No clearing pass.
`timescale 1ns / 1ps
module node_address_parser_core #(
  parameter int NUMBER_BITS = nap_pkg::DEF_NUMBER_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  nap_in_if.sink    in_chan,
  nap_out_if.source out_chan
);
  import nap_pkg::*;

  token_t q_token;
  logic   q_valid;
  logic   q_ready;

  nap_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_token (q_token),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  nap_back #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_token  (q_token),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> q_valid)
    else $error("accepted transaction not visible at queue head");

  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !$past(out_chan.valid) |-> $past(q_valid && q_ready))
    else $error("result appeared without a parse step");

  a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |-> !(q_valid && q_ready))
    else $error("parse step taken while result is stalled");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import nap_pkg::*;

  localparam int LIMIT       = 200_000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 20;
  localparam int RANDOM_CHARS = 500;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               first;
    logic [LEVEL_W-1:0] start_level;
  } char_item_t;

  typedef struct packed {
    logic               status;
    logic [LEVEL_W-1:0] level;
    logic [FIELD_W-1:0] zone;
    logic [FIELD_W-1:0] net;
    logic [FIELD_W-1:0] node;
    logic [FIELD_W-1:0] point;
    logic               zone_written;
    logic               net_written;
    logic               node_written;
  } parse_result_t;

  typedef enum {
    S_IDLE, S_SEG, S_DIGITS, S_STAR, S_PT_START, S_PT_DIGITS, S_PT_STAR
  } parse_state_t;

  logic clk;
  logic rst_n;

  nap_in_if  in_chan ();
  nap_out_if out_chan ();

  node_address_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  char_item_t    char_queue[$];
  parse_result_t pending_results[$];
  logic [CHAR_W-1:0] addr_chars[$];

  int stim_total   = 0;
  int counted_chars = 0;
  int addr_cnt     = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int error_results = 0;
  int mismatches   = 0;
  int cycle_cnt    = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int blocked_cnt  = 0;

  parse_state_t       p_state = S_IDLE;
  logic [ORDER_W-1:0] p_order = ORD_NONE;
  logic [LEVEL_W-1:0] p_level = LVL_NONE;
  logic [FIELD_W-1:0] p_acc   = '0;
  logic [FIELD_W-1:0] p_zone  = '0;
  logic [FIELD_W-1:0] p_net   = '0;
  logic [FIELD_W-1:0] p_node  = '0;
  logic [FIELD_W-1:0] p_point = '0;
  logic               p_zw    = 1'b0;
  logic               p_nw    = 1'b0;
  logic               p_ndw   = 1'b0;

  function automatic bit parse_char(input char_item_t it, output parse_result_t r);
    bit done;
    bit err;
    bit is_dig;
    logic [3:0] dig;
    done   = 1'b0;
    err    = 1'b0;
    is_dig = it.ch inside {[CH_ZERO:CH_NINE]};
    dig    = 4'(it.ch - CH_ZERO);
    r      = '0;
    if (it.first) begin
      p_order = ORD_NONE;
      p_acc   = '0;
      p_zone  = '0;
      p_net   = '0;
      p_node  = '0;
      p_point = '0;
      p_zw    = 1'b0;
      p_nw    = 1'b0;
      p_ndw   = 1'b0;
      p_level = it.start_level;
      p_state = S_SEG;
    end
    if (it.first && it.ch == CH_DOT) begin
      if (p_level >= LVL_NODE) begin
        p_state = S_PT_START;
      end else begin
        done = 1'b1;
        err  = 1'b1;
      end
    end else begin
      case (p_state)
        S_SEG: begin
          if (it.ch == CH_STAR && p_level < LVL_NODE) begin
            p_state = S_STAR;
          end else if (is_dig) begin
            p_acc   = FIELD_W'(dig);
            p_state = S_DIGITS;
          end else begin
            done = 1'b1;
            err  = 1'b1;
          end
        end
        S_DIGITS: begin
          if (is_dig) begin
            p_acc = FIELD_W'(p_acc * 10 + dig);
          end else if (it.ch == CH_COLON) begin
            if (p_order != ORD_NONE) begin
              done = 1'b1;
              err  = 1'b1;
            end else begin
              p_order = ORD_ZONE;
              p_zone  = p_acc;
              p_zw    = 1'b1;
              p_level = LVL_ZONE;
              p_state = S_SEG;
            end
          end else if (it.ch == CH_SLASH) begin
            if (p_acc == 0 || p_order > ORD_ZONE || p_level == LVL_NONE) begin
              done = 1'b1;
              err  = 1'b1;
            end else begin
              p_net   = p_acc;
              p_nw    = 1'b1;
              p_order = ORD_NET;
              p_level = LVL_NET;
              p_state = S_SEG;
            end
          end else if (it.ch == CH_NUL && p_level == LVL_NODE) begin
            p_point = p_acc;
            p_level = LVL_POINT;
            done    = 1'b1;
          end else if (it.ch == CH_NUL || it.ch == CH_DOT) begin
            if ((p_level < LVL_NET || p_order != ORD_NONE) && p_order != ORD_NET) begin
              done = 1'b1;
              err  = 1'b1;
            end else begin
              p_node  = p_acc;
              p_ndw   = 1'b1;
              p_level = LVL_NODE;
              if (it.ch == CH_NUL) begin
                done = 1'b1;
              end else begin
                p_state = S_SEG;
              end
            end
          end else begin
            done = 1'b1;
            err  = 1'b1;
          end
        end
        S_STAR: begin
          done = 1'b1;
          err  = (it.ch != CH_NUL);
        end
        S_PT_START: begin
          if (is_dig) begin
            p_acc   = FIELD_W'(dig);
            p_point = p_acc;
            p_state = S_PT_DIGITS;
          end else if (it.ch == CH_STAR) begin
            p_state = S_PT_STAR;
          end else begin
            done = 1'b1;
            err  = 1'b1;
          end
        end
        S_PT_DIGITS: begin
          if (is_dig) begin
            p_acc   = FIELD_W'(p_acc * 10 + dig);
            p_point = p_acc;
          end else begin
            done = 1'b1;
            err  = (it.ch != CH_NUL);
            if (it.ch == CH_NUL) begin
              p_level = LVL_POINT;
            end
          end
        end
        S_PT_STAR: begin
          done = 1'b1;
          err  = (it.ch != CH_NUL);
          if (it.ch == CH_NUL) begin
            p_level = LVL_NODE;
          end
        end
        default: begin
          p_state = S_IDLE;
        end
      endcase
    end
    if (done) begin
      r = '{status: err, level: p_level, zone: p_zone, net: p_net, node: p_node,
            point: p_point, zone_written: p_zw, net_written: p_nw,
            node_written: p_ndw};
      p_state = S_IDLE;
    end
    return done;
  endfunction

  task automatic put_char(input logic [CHAR_W-1:0] c);
    addr_chars.push_back(c);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_char(s[i]);
    end
  endtask

  task automatic put_digits();
    int n;
    if ($urandom_range(9) == 0) begin
      put_char(CH_ZERO);
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
      repeat (n) put_char(CHAR_W'(CH_ZERO + $urandom_range(9)));
    end
  endtask

  task automatic put_full_form();
    if ($urandom_range(1)) begin
      put_digits();
      put_char(CH_COLON);
    end
    if ($urandom_range(9) < 7) begin
      put_digits();
      put_char(CH_SLASH);
      if ($urandom_range(11) == 0) begin
        put_digits();
        put_char($urandom_range(1) ? CH_COLON : CH_SLASH);
      end
    end
    if ($urandom_range(9) != 0) begin
      put_digits();
    end
    if ($urandom_range(9) < 4) begin
      put_char(CH_DOT);
      put_digits();
    end
    put_char(CH_NUL);
  endtask

  task automatic send_addr(input logic [LEVEL_W-1:0] lvl);
    for (int i = 0; i < addr_chars.size(); i++) begin
      char_queue.push_back('{ch: addr_chars[i], first: (i == 0), start_level: lvl});
    end
    counted_chars += addr_chars.size();
    addr_cnt++;
    addr_chars.delete();
  endtask

  task automatic send_strays(input int n);
    repeat (n) begin
      char_queue.push_back('{ch: CHAR_W'($urandom_range(255)), first: 1'b0,
                             start_level: LEVEL_W'($urandom_range(7))});
    end
  endtask

  function automatic int send_idle_pct(input int n);
    if (n < stim_total / 3) return 13;
    if (n < 2 * stim_total / 3) return 55;
    return 0;
  endfunction

  function automatic int recv_idle_pct(input int n);
    if (n < stim_total / 3) return 55;
    if (n < 2 * stim_total / 3) return 13;
    return 0;
  endfunction

  task automatic report_error(input string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int idx,
                             input logic [FIELD_W-1:0] got,
                             input logic [FIELD_W-1:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d %s: got %0h, expected %0h", idx, name, got, want));
    end
  endtask

  always @(posedge clk) begin : drive_chars
    char_item_t    taken;
    char_item_t    nxt;
    parse_result_t res;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        taken = '{ch: in_chan.ch, first: in_chan.first, start_level: in_chan.start_level};
        if (parse_char(taken, res)) begin
          pending_results.push_back(res);
        end
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct(accepted_cnt)) begin
          nxt = char_queue.pop_front();
          in_chan.valid       <= 1'b1;
          in_chan.ch          <= nxt.ch;
          in_chan.first       <= nxt.first;
          in_chan.start_level <= nxt.start_level;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : hold_off
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (!hold_done && accepted_cnt >= 3 * stim_total / 4) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      if (hold_left != 0 && in_chan.valid && !in_chan.ready) begin
        blocked_cnt <= blocked_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin : watch_results
    parse_result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (pending_results.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = pending_results.pop_front();
          check_field("status", results_seen, FIELD_W'(out_chan.status),
                      FIELD_W'(want.status));
          check_field("level", results_seen, FIELD_W'(out_chan.level),
                      FIELD_W'(want.level));
          check_field("zone", results_seen, out_chan.zone, want.zone);
          check_field("net", results_seen, out_chan.net, want.net);
          check_field("node", results_seen, out_chan.node, want.node);
          check_field("point", results_seen, out_chan.point, want.point);
          check_field("zone_written", results_seen, FIELD_W'(out_chan.zone_written),
                      FIELD_W'(want.zone_written));
          check_field("net_written", results_seen, FIELD_W'(out_chan.net_written),
                      FIELD_W'(want.net_written));
          check_field("node_written", results_seen, FIELD_W'(out_chan.node_written),
                      FIELD_W'(want.node_written));
        end
        results_seen <= results_seen + 1;
        if (out_chan.status === 1'b1) begin
          error_results <= error_results + 1;
        end
      end
      out_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct(accepted_cnt));
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("node_address_parser_core verification failed");
      $finish;
    end
  end

  initial begin
    int kind;
    int keep;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.ch          = '0;
    in_chan.first       = 1'b0;
    in_chan.start_level = '0;
    out_chan.ready      = 1'b0;

    put_char(CH_NUL);
    send_addr(LVL_NONE);
    send_strays(1);
    put_text(".7");
    put_char(CH_NUL);
    send_addr(3'd7);
    put_text(".*");
    put_char(CH_NUL);
    send_addr(LVL_NODE);
    put_text(".5");
    put_char(8'hC5);
    send_addr(LVL_POINT);
    put_char(CH_STAR);
    put_char(CH_NUL);
    send_addr(LVL_NONE);
    put_text("9:");
    send_addr(LVL_NET);
    put_text("1:2/3.4");
    put_char(CH_NUL);
    send_addr(LVL_NONE);

    counted_chars = 0;
    while (counted_chars < RANDOM_CHARS) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        put_full_form();
        send_addr(LEVEL_W'($urandom_range(7)));
      end else if (kind < 65) begin
        put_char(CH_DOT);
        if ($urandom_range(3) == 0) begin
          put_char(CH_STAR);
        end else begin
          put_digits();
        end
        put_char(CH_NUL);
        send_addr(LEVEL_W'(($urandom_range(4) != 0) ? $urandom_range(3, 7) : $urandom_range(2)));
      end else if (kind < 72) begin
        if ($urandom_range(9) < 3) begin
          put_digits();
          put_char(CH_COLON);
        end
        if ($urandom_range(9) < 2) begin
          put_digits();
          put_char(CH_SLASH);
        end
        put_char(CH_STAR);
        if ($urandom_range(9) == 0) begin
          put_char(CHAR_W'($urandom_range(255)));
        end
        put_char(CH_NUL);
        send_addr(LEVEL_W'($urandom_range(7)));
      end else if (kind < 80) begin
        put_full_form();
        keep = $urandom_range(1, addr_chars.size() - 1);
        while (addr_chars.size() > keep) void'(addr_chars.pop_back());
        send_addr(LEVEL_W'($urandom_range(7)));
      end else if (kind < 88) begin
        put_full_form();
        addr_chars[$urandom_range(addr_chars.size() - 1)] = CHAR_W'($urandom_range(255));
        send_addr(LEVEL_W'($urandom_range(7)));
      end else begin
        repeat ($urandom_range(1, 6)) put_char(CHAR_W'($urandom_range(255)));
        send_addr(LEVEL_W'($urandom_range(7)));
      end
      if ($urandom_range(99) < 15) begin
        send_strays($urandom_range(1, 3));
      end
    end
    stim_total = char_queue.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (char_queue.size() != 0 || in_chan.valid) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    $display("Sent %0d characters in %0d addresses, checked %0d results (%0d syntax errors).",
             accepted_cnt, addr_cnt, results_seen, error_results);
    $display("Output held off for %0d cycles; input back-pressured for %0d of them.",
             HOLD_CYCLES, blocked_cnt);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("node_address_parser_core verification clean");
    end else begin
      $display("node_address_parser_core verification failed");
    end
    $finish;
  end

endmodule
